// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/qspc_pkg.sv =====
// shared types, constants and helpers of the quadrature speed pid controller
`timescale 1ns / 1ps

package qspc_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes, one 32-bit word each
   localparam logic [2:0] REG_KP   = 3'd0;
   localparam logic [2:0] REG_KI   = 3'd1;
   localparam logic [2:0] REG_KD   = 3'd2;
   localparam logic [2:0] REG_RPM  = 3'd3;
   localparam logic [2:0] REG_MRPS = 3'd4;

   // item kinds on the request channel
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // reset values of the gain registers
   localparam logic signed [15:0] KP_RESET   = 16'sd512;
   localparam logic signed [15:0] KI_RESET   = 16'sd0;
   localparam logic signed [15:0] KD_RESET   = 16'sd0;
   localparam logic [23:0]        RPM_RESET  = 24'd117965;
   localparam logic [27:0]        MRPS_RESET = 28'd1966080;

   // 0.6 in unsigned q16
   localparam logic [15:0] DAMP_Q16 = 16'd39322;

   typedef struct packed {
      logic              kind;
      logic              chan_a;
      logic              chan_b;
      logic signed [15:0] setpoint_rpm;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [15:0] speed_rpm;
      logic signed [15:0] speed_milli_rps;
      logic [7:0]         duty;
      logic               direction;
   } rsp_item_type;

   typedef struct packed {
      logic signed [15:0] kp;
      logic signed [15:0] ki;
      logic signed [15:0] kd;
      logic [23:0]        rpm_gain;
      logic [27:0]        mrps_gain;
   } gains_type;

   // controller to datapath commands, at most one step per cycle
   typedef struct packed {
      logic load_enc;
      logic load_tick;
      logic mul_rpm;
      logic mul_mrps;
      logic calc_err;
      logic calc_term;
      logic mul_int;
      logic sat_int;
      logic mul_pid;
      logic sum_pid;
      logic set_duty;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

   // quadrature step from the 4-bit {old a,old b,new a,new b} history
   function automatic logic signed [1:0] quad_step(input logic [3:0] hist);
      logic signed [1:0] step;
      unique case (hist)
         4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
         default: step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage

// ===== hw/rtl/qspc_csr.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module qspc_csr
   import qspc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output gains_type             gains
);

   gains_type  gains_ff, gains_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign gains      = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_KP:   gains_in.kp        = csr_pwdata[15:0];
            REG_KI:   gains_in.ki        = csr_pwdata[15:0];
            REG_KD:   gains_in.kd        = csr_pwdata[15:0];
            REG_RPM:  gains_in.rpm_gain  = csr_pwdata[23:0];
            REG_MRPS: gains_in.mrps_gain = csr_pwdata[27:0];
            default: ;  // unmapped, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_KP:   csr_prdata = {16'd0, gains_ff.kp};
         REG_KI:   csr_prdata = {16'd0, gains_ff.ki};
         REG_KD:   csr_prdata = {16'd0, gains_ff.kd};
         REG_RPM:  csr_prdata = {8'd0, gains_ff.rpm_gain};
         REG_MRPS: csr_prdata = {4'd0, gains_ff.mrps_gain};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp        <= KP_RESET;
         gains_ff.ki        <= KI_RESET;
         gains_ff.kd        <= KD_RESET;
         gains_ff.rpm_gain  <= RPM_RESET;
         gains_ff.mrps_gain <= MRPS_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

// ===== hw/rtl/qspc_ctrl.sv =====
// sequencer that steps the datapath through one item
`timescale 1ns / 1ps

module qspc_ctrl
   import qspc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RPM  = 4'd1;
   localparam logic [3:0] ST_MRPS = 4'd2;
   localparam logic [3:0] ST_ERR  = 4'd3;
   localparam logic [3:0] ST_TERM = 4'd4;
   localparam logic [3:0] ST_IMUL = 4'd5;
   localparam logic [3:0] ST_ISAT = 4'd6;
   localparam logic [3:0] ST_PMUL = 4'd7;
   localparam logic [3:0] ST_SUM  = 4'd8;
   localparam logic [3:0] ST_DUTY = 4'd9;
   localparam logic [3:0] ST_RESP = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.load_enc  = accept && (req_kind == KIND_SAMPLE);
      cmd.load_tick = accept && (req_kind == KIND_TICK);
      cmd.mul_rpm   = (state_ff == ST_RPM);
      cmd.mul_mrps  = (state_ff == ST_MRPS);
      cmd.calc_err  = (state_ff == ST_ERR);
      cmd.calc_term = (state_ff == ST_TERM);
      cmd.mul_int   = (state_ff == ST_IMUL);
      cmd.sat_int   = (state_ff == ST_ISAT);
      cmd.mul_pid   = (state_ff == ST_PMUL);
      cmd.sum_pid   = (state_ff == ST_SUM);
      cmd.set_duty  = (state_ff == ST_DUTY);
      cmd.load_rsp  = (state_ff == ST_RESP);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (req_kind == KIND_TICK) ? ST_RPM : ST_RESP;
         end
         ST_RPM:  state_in = ST_MRPS;
         ST_MRPS: state_in = ST_ERR;
         ST_ERR:  state_in = ST_TERM;
         ST_TERM: state_in = ST_IMUL;
         ST_IMUL: state_in = ST_ISAT;
         ST_ISAT: state_in = ST_PMUL;
         ST_PMUL: state_in = ST_SUM;
         ST_SUM:  state_in = ST_DUTY;
         ST_DUTY: state_in = ST_RESP;
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/qspc_dp.sv =====
// decoder, speed scaling, pid arithmetic and the result register
`timescale 1ns / 1ps

module qspc_dp
   import qspc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_data,
   input  dp_cmd_type    cmd,
   input  gains_type     gains,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_data
);

   // item state
   logic [3:0]         hist_ff;
   logic [31:0]        count_ff;
   logic [31:0]        count_tick_ff;
   logic signed [39:0] integ_ff;
   logic signed [17:0] prior_ff;
   logic signed [15:0] rpm_ff;
   logic signed [15:0] mrps_ff;
   logic [7:0]         duty_ff;
   logic               dir_ff;

   // working registers of a speed tick
   logic signed [15:0] setpoint_ff;
   logic [31:0]        mag_ff;
   logic               neg_ff;
   logic [59:0]        prod_ff;
   logic signed [17:0] err_ff;
   logic signed [17:0] deriv_ff;
   logic [40:0]        tmag_ff;
   logic               tneg_ff;
   logic [56:0]        iprod_ff;
   logic signed [33:0] p_ff;
   logic signed [33:0] d_ff;
   logic signed [55:0] i_ff;
   logic signed [57:0] sum_ff;

   logic               rsp_valid_ff;
   rsp_item_type       rsp_data_ff;

   logic [3:0]         hist_in;
   logic signed [1:0]  step;
   logic [31:0]        diff;
   logic [27:0]        gain_sel;
   logic signed [15:0] speed_sat;
   logic [17:0]        abs_sp;
   logic [17:0]        abs_rpm;
   logic signed [40:0] term;
   logic [40:0]        imag;
   logic [39:0]        integ_in;
   logic               rsp_free;

   // counts * gain / 65536 toward zero, saturated to 16 bits
   function automatic logic signed [15:0] sat_speed(input logic [59:0] prod,
                                                    input logic        neg);
      logic [43:0] scaled;
      scaled = prod[59:16];
      if (neg) begin
         return (scaled > 44'd32768) ? 16'sh8000 : 16'(16'd0 - scaled[15:0]);
      end else begin
         return (scaled > 44'd32767) ? 16'sh7fff : 16'(scaled[15:0]);
      end
   endfunction

   assign hist_in   = {hist_ff[1:0], req_data.chan_a, req_data.chan_b};
   assign step      = quad_step(hist_in);
   assign diff      = count_ff - count_tick_ff;
   assign gain_sel  = cmd.mul_rpm ? {4'd0, gains.rpm_gain} : gains.mrps_gain;
   assign speed_sat = sat_speed(prod_ff, neg_ff);

   assign abs_sp  = setpoint_ff[15] ? 18'(18'd0 - {{2{setpoint_ff[15]}}, setpoint_ff})
                                    : {2'd0, setpoint_ff};
   assign abs_rpm = rpm_ff[15] ? 18'(18'd0 - {{2{rpm_ff[15]}}, rpm_ff})
                               : {2'd0, rpm_ff};

   assign term = $signed({integ_ff[39], integ_ff})
               + $signed({{7{err_ff[17]}}, err_ff, 16'd0});

   // damped integral, magnitude saturated to 40 bits signed
   assign imag = iprod_ff[56:16];
   always_comb begin
      if (imag > 41'h7f_ffff_ffff) begin
         integ_in = tneg_ff ? 40'h80_0000_0000 : 40'h7f_ffff_ffff;
      end else begin
         integ_in = tneg_ff ? 40'(40'd0 - imag[39:0]) : imag[39:0];
      end
   end

   assign rsp_free        = !rsp_valid_ff || !rsp_stall;
   assign status.rsp_free = rsp_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff       <= '0;
         count_ff      <= '0;
         count_tick_ff <= '0;
         integ_ff      <= '0;
         prior_ff      <= '0;
         rpm_ff        <= '0;
         mrps_ff       <= '0;
         duty_ff       <= '0;
         dir_ff        <= 1'b0;
      end else begin
         if (cmd.load_enc) begin
            hist_ff  <= hist_in;
            count_ff <= count_ff + {{30{step[1]}}, step};
         end
         if (cmd.load_tick) begin
            count_tick_ff <= count_ff;
         end
         if (cmd.mul_mrps) begin
            rpm_ff <= speed_sat;
         end
         if (cmd.calc_err) begin
            mrps_ff <= speed_sat;
         end
         if (cmd.sat_int) begin
            integ_ff <= integ_in;
            prior_ff <= err_ff;
         end
         if (cmd.set_duty) begin
            if (sum_ff[57] || (sum_ff == '0)) begin
               duty_ff <= 8'd0;
            end else if (|sum_ff[57:32]) begin
               duty_ff <= 8'd255;
            end else begin
               duty_ff <= sum_ff[31:24];
            end
            dir_ff <= (setpoint_ff > 16'sd0);
         end
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load_tick) begin
         setpoint_ff <= req_data.setpoint_rpm;
         neg_ff      <= diff[31];
         mag_ff      <= diff[31] ? 32'(32'd0 - diff) : diff;
      end
      if (cmd.mul_rpm || cmd.mul_mrps) begin
         prod_ff <= mag_ff * gain_sel;  // one shared 32x28 multiplier
      end
      if (cmd.calc_err) begin
         err_ff <= $signed(abs_sp - abs_rpm);
      end
      if (cmd.calc_term) begin
         tneg_ff <= term[40];
         tmag_ff <= term[40] ? 41'(41'd0 - term) : term;
      end
      if (cmd.mul_int) begin
         iprod_ff <= tmag_ff * DAMP_Q16;
      end
      if (cmd.sat_int) begin
         deriv_ff <= err_ff - prior_ff;
      end
      if (cmd.mul_pid) begin
         p_ff <= $signed(gains.kp) * err_ff;
         d_ff <= $signed(gains.kd) * deriv_ff;
         i_ff <= $signed(gains.ki) * integ_ff;
      end
      if (cmd.sum_pid) begin
         sum_ff <= $signed({{8{p_ff[33]}}, p_ff, 16'd0})
                 + $signed({{8{d_ff[33]}}, d_ff, 16'd0})
                 + $signed({{2{i_ff[55]}}, i_ff});
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp && rsp_free) begin
         rsp_data_ff.position        <= count_ff;
         rsp_data_ff.speed_rpm       <= rpm_ff;
         rsp_data_ff.speed_milli_rps <= mrps_ff;
         rsp_data_ff.duty            <= duty_ff;
         rsp_data_ff.direction       <= dir_ff;
      end
   end

endmodule

// ===== hw/rtl/quadrature_speed_pid_controller.sv =====
// top level of the quadrature encoder speed regulator with pid drive
`timescale 1ns / 1ps
//
//   channel   ports              direction   moves
//   req       req_valid/stall    in          encoder sample or speed tick item
//   rsp       rsp_valid/stall    out         position, speeds, duty, direction
//   csr       csr_p*             in/out      gains, apb-style, 4-byte spaced
//
// an encoder sample: accept, then load of the result register
// a speed tick: the controller walks the chain one step per cycle
//   (speed scaling on one shared multiplier, integral damping, pid products,
//   sum, clamp)
// one item in flight; req_stall is high from accept until its result is loaded
// rsp_stall holds the result register and keeps the item from finishing
// synchronous active-high reset clears all regulator state and the gains
//   return to their defaults; no clearing pass is needed

module quadrature_speed_pid_controller
   import qspc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   gains_type     gains;
   dp_cmd_type    cmd;
   dp_status_type status;

   // gain registers
   qspc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   // sequencer: picks path by item kind, one step per cycle unless rsp stalls
   qspc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and held values, result register at the output
   qspc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .gains     (gains),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/qspc_checker.sv =====
// port-level checks of the speed regulator and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qspc_checker
   import qspc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_data), "stalled result changed")

   // one item at a time: an accepted item blocks the next cycle
   `ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall,
                req_stall, "item accepted back to back")

   // reset empties the result register
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind quadrature_speed_pid_controller qspc_checker u_qspc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
// self-checking testbench of the quadrature speed pid controller
`timescale 1ns / 1ps

module tb_top;
   import qspc_pkg::*;

   // register map, one 32-bit word per register
   localparam int NUM_REGS = 5;
   localparam int TOP_INDEX = (2 ** CSR_ADDR_W) / 4 - 1;

   // step per {old a, old b, new a, new b} history
   localparam int QUAD_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
   // channel levels in forward order, one count per step
   localparam logic [1:0] GRAY_CYCLE [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

   localparam int RANDOM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   quadrature_speed_pid_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // regulator state as the testbench sees it, updated once per accepted item
   // ---------------------------------------------------------------------
   gains_type          gain_cfg;
   logic [3:0]         quad_hist = '0;
   logic [31:0]        enc_count = '0;
   logic [31:0]        count_at_last_tick = '0;
   longint             integral_q16 = 0;
   int                 prev_error = 0;
   logic signed [15:0] rpm_now = '0;
   logic signed [15:0] mrps_now = '0;
   logic [7:0]         duty_now = '0;
   logic               dir_now = 1'b0;

   // queues between the stimulus, the driver and the monitor
   req_item_type pending_req [$];
   rsp_item_type predicted_rsp [$];
   rsp_item_type want_rsp;
   int           in_flight = 0;
   logic [1:0]   gen_ab = 2'b00;
   bit           steady_flow = 1'b0;

   int error_count = 0;
   int results_checked = 0;
   int samples_sent = 0;
   int ticks_sent = 0;
   int gain_settings = 0;
   int duty_full = 0;
   int duty_zero = 0;

   // counts * gain / 65536, truncated toward zero, saturated to 16 bits
   function automatic logic signed [15:0] scale_speed(input longint counts,
                                                      input logic [27:0] gain);
      logic [63:0] mag;
      mag = (counts < 0) ? -counts : counts;
      mag = (mag * 64'(gain)) >> 16;
      if (counts < 0)
         return (mag > 64'd32768) ? 16'h8000 : 16'(-longint'(mag));
      return (mag > 64'd32767) ? 16'h7FFF : 16'(mag);
   endfunction

   // advances the regulator by one item and returns the result it must produce
   function automatic rsp_item_type predict_regulator(input req_item_type it);
      rsp_item_type res;
      longint       counts;
      longint       t;
      longint       sum;
      logic [63:0]  umag;
      shortint      sp;
      int           err;
      int           deriv;
      int           abs_sp;
      int           abs_rpm;
      bit           neg;
      if (it.kind == KIND_TICK) begin
         // speed from the counts gathered since the previous tick
         counts = longint'($signed(enc_count - count_at_last_tick));
         count_at_last_tick = enc_count;
         rpm_now = scale_speed(counts, 28'(gain_cfg.rpm_gain));
         mrps_now = scale_speed(counts, gain_cfg.mrps_gain);

         // error on magnitudes, so reverse runs regulate the same way
         sp = it.setpoint_rpm;
         abs_sp = (sp < 0) ? -int'(sp) : int'(sp);
         abs_rpm = (rpm_now < 0) ? -int'(rpm_now) : int'(rpm_now);
         err = abs_sp - abs_rpm;

         // damped integral in q16, magnitude truncated, held to 40 bits
         t = integral_q16 + longint'(err) * 65536;
         neg = t < 0;
         umag = neg ? -t : t;
         umag = (umag * 64'(DAMP_Q16)) >> 16;
         if (umag > 64'h7F_FFFF_FFFF)
            umag = neg ? 64'h80_0000_0000 : 64'h7F_FFFF_FFFF;
         integral_q16 = neg ? -longint'(umag) : longint'(umag);

         deriv = err - prev_error;
         prev_error = err;

         // q8.8 gains on q16 terms give a q24 drive
         sum = longint'($signed(gain_cfg.kp)) * err * 65536
             + longint'($signed(gain_cfg.kd)) * deriv * 65536
             + longint'($signed(gain_cfg.ki)) * integral_q16;
         if (sum <= 0)
            duty_now = 8'd0;
         else if (sum >= (longint'(256) << 24))
            duty_now = 8'd255;
         else
            duty_now = 8'(sum >>> 24);
         dir_now = (sp > 0);
      end else begin
         quad_hist = {quad_hist[1:0], it.chan_a, it.chan_b};
         enc_count = enc_count + 32'(QUAD_DELTA[quad_hist]);
      end
      res.position = enc_count;
      res.speed_rpm = rpm_now;
      res.speed_milli_rps = mrps_now;
      res.duty = duty_now;
      res.direction = dir_now;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d (result %0d)",
               what, got, want, results_checked);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // item builders; unused fields always carry random values
   // ---------------------------------------------------------------------
   function automatic void push_sample(input logic [1:0] ab);
      req_item_type it;
      it.kind = KIND_SAMPLE;
      it.chan_a = ab[1];
      it.chan_b = ab[0];
      it.setpoint_rpm = 16'($urandom);
      pending_req.push_back(it);
      gen_ab = ab;
   endfunction

   function automatic void push_tick(input logic [15:0] sp);
      req_item_type it;
      it.kind = KIND_TICK;
      it.chan_a = 1'($urandom);
      it.chan_b = 1'($urandom);
      it.setpoint_rpm = sp;
      pending_req.push_back(it);
   endfunction

   // clean quadrature run from the current levels, one count per sample
   function automatic void queue_walk(input int steps, input bit forward);
      int pos;
      pos = 0;
      for (int k = 0; k < 4; k++)
         if (GRAY_CYCLE[k] == gen_ab) pos = k;
      repeat (steps) begin
         pos = forward ? (pos + 1) % 4 : (pos + 3) % 4;
         push_sample(GRAY_CYCLE[pos]);
      end
   endfunction

   // mostly clean runs between ticks, with some glitches and level jumps
   function automatic void queue_random_items(input int n);
      int          added;
      int          len;
      int          r;
      logic [15:0] sp;
      added = 0;
      while (added < n) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            push_sample(2'($urandom));
            added++;
         end else if (r < 50) begin
            case ($urandom_range(0, 9))
               0: sp = 16'h8000;
               1: sp = 16'h7FFF;
               2: sp = 16'h0000;
               3, 4, 5: sp = 16'($urandom);
               default: sp = 16'($urandom_range(0, 4000) - 2000);
            endcase
            push_tick(sp);
            added++;
         end else begin
            // now and then a long run, enough to saturate the speed at high gains
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 10);
            queue_walk(len, 1'($urandom_range(0, 1)));
            added += len;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // configuration writes, only while nothing is in flight
   // ---------------------------------------------------------------------
   task automatic apply_gains(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] rpm,
                              input logic [31:0] mrps);
      logic [31:0] words [NUM_REGS+1];
      int          idx;
      words[REG_KP] = kp;
      words[REG_KI] = ki;
      words[REG_KD] = kd;
      words[REG_RPM] = rpm;
      words[REG_MRPS] = mrps;
      // last write lands on an unmapped address and must change nothing
      words[NUM_REGS] = $urandom;
      for (int i = 0; i <= NUM_REGS; i++) begin
         idx = (i < NUM_REGS) ? i : $urandom_range(NUM_REGS, TOP_INDEX);
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= CSR_ADDR_W'(4 * idx);
         csr_pwdata <= words[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         case (idx)
            REG_KP:   gain_cfg.kp = words[i][15:0];
            REG_KI:   gain_cfg.ki = words[i][15:0];
            REG_KD:   gain_cfg.kd = words[i][15:0];
            REG_RPM:  gain_cfg.rpm_gain = words[i][23:0];
            REG_MRPS: gain_cfg.mrps_gain = words[i][27:0];
            default: ;
         endcase
      end
      gain_settings++;
   endtask

   // sender holds off until every item has produced its result and the block has settled
   task automatic wait_until_drained();
      while (pending_req.size() != 0 || in_flight != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: presents the next pending item, holds it while stalled
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(predict_regulator(req_data));
            if (req_data.kind == KIND_TICK) ticks_sent++;
            else samples_sent++;
         end
         // a new item only once the previous one has gone; about one gap in ten
         if (!req_valid || !req_stall) begin
            if (pending_req.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 10)) begin
               req_data <= pending_req.pop_front();
               in_flight++;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks each accepted result against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch("unexpected result position", rsp_data.position, 0);
            end else begin
               want_rsp = predicted_rsp.pop_front();
               in_flight--;
               if (rsp_data.position !== want_rsp.position)
                  report_mismatch("position", rsp_data.position, want_rsp.position);
               if (rsp_data.speed_rpm !== want_rsp.speed_rpm)
                  report_mismatch("speed_rpm", rsp_data.speed_rpm, want_rsp.speed_rpm);
               if (rsp_data.speed_milli_rps !== want_rsp.speed_milli_rps)
                  report_mismatch("speed_milli_rps", rsp_data.speed_milli_rps,
                                  want_rsp.speed_milli_rps);
               if (rsp_data.duty !== want_rsp.duty)
                  report_mismatch("duty", rsp_data.duty, want_rsp.duty);
               if (rsp_data.direction !== want_rsp.direction)
                  report_mismatch("direction", rsp_data.direction, want_rsp.direction);
               if (want_rsp.duty == 8'd255) duty_full++;
               if (want_rsp.duty == 8'd0) duty_zero++;
               results_checked++;
            end
         end
         // receiver backpressure, stalled with a probability of about one in ten
         rsp_stall <= !steady_flow && ($urandom_range(0, 99) < 10);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus: directed items on reset gains, then random phases with
   // different gain settings, extremes among them
   // ---------------------------------------------------------------------
   initial begin
      gain_cfg = '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET,
                   rpm_gain: RPM_RESET, mrps_gain: MRPS_RESET};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tick at rest, zero setpoint gives reverse direction
      push_tick(16'h0000);
      // forward run then full positive setpoint, duty clamps high
      queue_walk(8, 1'b1);
      push_tick(16'h7FFF);
      // reverse run then most negative setpoint
      queue_walk(4, 1'b0);
      push_tick(16'h8000);
      // level jump over both channels and a repeated level count nothing
      push_sample(~gen_ab);
      push_sample(gen_ab);
      // smallest setpoints either side of zero
      push_tick(16'h0001);
      push_tick(16'hFFFF);
      queue_walk(2, 1'b1);
      push_tick(16'h0000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_drained();
         case (p)
            0: apply_gains(32'd384, 32'd96, 32'd64, 32'd117965, 32'd1966080);
            1: apply_gains(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFF_FFFF, 32'hFFF_FFFF);
            2: apply_gains(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'd0, 32'd0);
            3: apply_gains(32'd256, 32'd128, 32'h0000_FF00, 32'd117965, 32'd1966080);
            5: apply_gains(32'h0000_FE00, 32'd16, 32'd512, 32'hFF_FFFF, 32'd1);
            default: apply_gains($urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         // one phase runs with no gaps on either side
         steady_flow = (p == 3);
         queue_random_items(ITEMS_PER_PHASE);
      end

      wait_until_drained();
      steady_flow = 1'b0;
      if (predicted_rsp.size() != 0)
         report_mismatch("results never delivered", predicted_rsp.size(), 0);
      $display("checked %0d results from %0d encoder samples and %0d speed ticks",
               results_checked, samples_sent, ticks_sent);
      $display("gain settings used: %0d; duty at full scale %0d times, at zero %0d times",
               gain_settings, duty_full, duty_zero);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timed out with %0d items pending and %0d in flight",
               pending_req.size(), in_flight);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
